FILE: hw/rtl/ihrc_pkg.sv
// Package: shared types and constants of the IPv4 receive header check unit.
package ihrc_pkg;

    localparam int unsigned MIN_HEADER_BYTES = 20;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic [15:0] OFS_VERSION_IHL = 16'd0;
    localparam logic [15:0] OFS_TLEN_HI     = 16'd2;
    localparam logic [15:0] OFS_TLEN_LO     = 16'd3;
    localparam logic [15:0] OFS_IDENT_HI    = 16'd4;
    localparam logic [15:0] OFS_IDENT_LO    = 16'd5;
    localparam logic [15:0] OFS_FLAGS_HI    = 16'd6;
    localparam logic [15:0] OFS_FLAGS_LO    = 16'd7;
    localparam logic [15:0] OFS_PROTOCOL    = 16'd9;
    localparam logic [15:0] OFS_SOURCE      = 16'd12;
    localparam logic [15:0] OFS_DEST        = 16'd16;
    localparam logic [15:0] OFS_DEST_END    = 16'd19;

    localparam logic [3:0]  IP_VERSION_4    = 4'd4;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [7:0]  LOOPBACK_NET    = 8'd127;
    localparam logic [31:0] ADDR_BROADCAST  = 32'hffff_ffff;
    localparam logic [15:0] CHECKSUM_GOOD   = 16'hffff;
    localparam logic [15:0] BYTE_COUNT_MAX  = 16'hffff;

    localparam logic [1:0]  REG_ENABLE      = 2'd0;
    localparam logic [1:0]  REG_LOCAL_ADDR  = 2'd1;
    localparam logic [1:0]  REG_DHCP        = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_DELIVER  = 2'd0,
        VERDICT_FRAGMENT = 2'd1,
        VERDICT_DROP     = 2'd2
    } verdict_t;

    typedef struct packed {
        logic        format_bad;
        logic [7:0]  protocol;
        logic [31:0] src_address;
        logic [31:0] destination_address;
        logic [15:0] identification;
        logic [15:0] flags_word;
        logic [5:0]  header_length;
        logic [15:0] total_length;
    } pkt_summary_t;

    typedef struct packed {
        logic        interface_enabled;
        logic [31:0] local_address;
        logic        dhcp_negotiating;
    } cfg_t;

endpackage

FILE: hw/rtl/ihrc_byte_if.sv
// Interface: receive byte channel with valid/ready handshake.
interface ihrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

FILE: hw/rtl/ihrc_result_if.sv
// Interface: per-packet verdict channel with valid/ready handshake.
interface ihrc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [7:0]  protocol;
    logic [31:0] src_address;
    logic [31:0] destination_address;
    logic [15:0] identification;
    logic [15:0] fragment_offset;
    logic        more_frag;
    logic [5:0]  header_length;
    logic [15:0] payload_length;
    logic [31:0] received_count;
    logic [31:0] dropped_count;

    modport source (
        output valid, output verdict, output protocol, output src_address,
        output destination_address, output identification, output fragment_offset,
        output more_frag, output header_length, output payload_length,
        output received_count, output dropped_count, input ready
    );
    modport sink (
        input valid, input verdict, input protocol, input src_address,
        input destination_address, input identification, input fragment_offset,
        input more_frag, input header_length, input payload_length,
        input received_count, input dropped_count, output ready
    );
endinterface

FILE: hw/rtl/ihrc_front.sv
// Front end: per-byte header capture, checksum and format classification.
module ihrc_front
    import ihrc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    ihrc_byte_if.sink      rx,
    input  logic           push_ready,
    output logic           push_valid,
    output pkt_summary_t   push_data
);

    logic [15:0] index_reg, index_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  ver_ihl_reg, ver_ihl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    logic [15:0] idx;
    logic [7:0]  b;
    logic [5:0]  hdr;
    logic [15:0] hdr_wide;
    logic [16:0] sum_wide;
    logic [15:0] size;
    logic        take;

    assign rx.ready = push_ready;
    assign take     = rx.valid && push_ready;
    assign idx      = index_reg;
    assign b        = rx.data_byte;

    always_comb
    begin
        ver_ihl_next = ver_ihl_reg;
        tlen_next    = tlen_reg;
        ident_next   = ident_reg;
        flags_next   = flags_reg;
        proto_next   = proto_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        hold_next    = hold_reg;
        sum_next     = sum_reg;
        sum_wide     = '0;

        if (idx == OFS_VERSION_IHL) ver_ihl_next = b;
        if (idx == OFS_TLEN_HI)  tlen_next[15:8]  = b;
        if (idx == OFS_TLEN_LO)  tlen_next[7:0]   = b;
        if (idx == OFS_IDENT_HI) ident_next[15:8] = b;
        if (idx == OFS_IDENT_LO) ident_next[7:0]  = b;
        if (idx == OFS_FLAGS_HI) flags_next[15:8] = b;
        if (idx == OFS_FLAGS_LO) flags_next[7:0]  = b;
        if (idx == OFS_PROTOCOL) proto_next       = b;
        if (idx >= OFS_SOURCE && idx < OFS_DEST) src_next = {src_reg[23:0], b};
        if (idx >= OFS_DEST && idx <= OFS_DEST_END) dst_next = {dst_reg[23:0], b};

        hdr      = {ver_ihl_next[3:0], 2'b00};
        hdr_wide = {10'd0, hdr};

        if (idx < hdr_wide)
        begin
            if (!idx[0])
            begin
                hold_next = b;
            end
            else
            begin
                sum_wide = {1'b0, sum_reg} + {1'b0, hold_reg, b};
                sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end

        size = (idx == BYTE_COUNT_MAX) ? idx : idx + 16'd1;
        index_next = size;

        push_data.format_bad = (size < 16'(MIN_HEADER_BYTES))
                            || (ver_ihl_next[7:4] != IP_VERSION_4)
                            || (hdr_wide < 16'(MIN_HEADER_BYTES))
                            || (hdr_wide > size)
                            || (tlen_next < hdr_wide)
                            || (tlen_next > size)
                            || (sum_next != CHECKSUM_GOOD);
        push_data.protocol            = proto_next;
        push_data.src_address         = src_next;
        push_data.destination_address = dst_next;
        push_data.identification      = ident_next;
        push_data.flags_word          = flags_next;
        push_data.header_length       = hdr;
        push_data.total_length        = tlen_next;
    end

    assign push_valid = take && rx.frame_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            sum_reg     <= '0;
            hold_reg    <= '0;
            ver_ihl_reg <= '0;
            tlen_reg    <= '0;
            ident_reg   <= '0;
            flags_reg   <= '0;
            proto_reg   <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
        end
        else if (take)
        begin
            if (rx.frame_last)
            begin
                index_reg   <= '0;
                sum_reg     <= '0;
                hold_reg    <= '0;
                ver_ihl_reg <= '0;
                tlen_reg    <= '0;
                ident_reg   <= '0;
                flags_reg   <= '0;
                proto_reg   <= '0;
                src_reg     <= '0;
                dst_reg     <= '0;
            end
            else
            begin
                index_reg   <= index_next;
                sum_reg     <= sum_next;
                hold_reg    <= hold_next;
                ver_ihl_reg <= ver_ihl_next;
                tlen_reg    <= tlen_next;
                ident_reg   <= ident_next;
                flags_reg   <= flags_next;
                proto_reg   <= proto_next;
                src_reg     <= src_next;
                dst_reg     <= dst_next;
            end
        end
    end

endmodule

FILE: hw/rtl/ihrc_queue.sv
// Queue: short FIFO of packet summaries between front and back.
module ihrc_queue
    import ihrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  pkt_summary_t push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output pkt_summary_t pop_data
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    pkt_summary_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/ihrc_back.sv
// Back end: destination filter, verdict, counters and output register.
module ihrc_back
    import ihrc_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  pkt_summary_t   pop_data,
    ihrc_result_if.source  result
);

    logic [COUNTER_WIDTH-1:0] recv_reg, recv_next;
    logic [COUNTER_WIDTH-1:0] drop_reg, drop_next;
    logic        valid_reg;
    verdict_t    verdict_reg, verdict_next;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [15:0] ident_reg;
    logic [15:0] offset_reg, offset_next;
    logic        more_reg;
    logic [5:0]  hdr_reg;
    logic [15:0] payload_reg, payload_next;
    logic [31:0] recv_out_reg;
    logic [31:0] drop_out_reg;

    logic        accept;
    logic        drop;
    logic        take;

    assign pop_ready = !valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        accept = (pop_data.destination_address == cfg.local_address)
              || (pop_data.destination_address == ADDR_BROADCAST)
              || (pop_data.destination_address[31:24] == LOOPBACK_NET)
              || (cfg.dhcp_negotiating && pop_data.protocol == PROTO_UDP);
        drop = pop_data.format_bad || !cfg.interface_enabled || !accept;
        offset_next = {pop_data.flags_word[12:0], 3'b000};
        if (drop)
        begin
            verdict_next = VERDICT_DROP;
        end
        else if (!pop_data.flags_word[13] && offset_next == '0)
        begin
            verdict_next = VERDICT_DELIVER;
        end
        else
        begin
            verdict_next = VERDICT_FRAGMENT;
        end
        payload_next = drop ? '0 : pop_data.total_length - {10'd0, pop_data.header_length};
        recv_next    = drop ? recv_reg : recv_reg + COUNTER_WIDTH'(1);
        drop_next    = drop ? drop_reg + COUNTER_WIDTH'(1) : drop_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            recv_reg  <= '0;
            drop_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                recv_reg  <= recv_next;
                drop_reg  <= drop_next;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            verdict_reg  <= verdict_next;
            proto_reg    <= pop_data.protocol;
            src_reg      <= pop_data.src_address;
            dst_reg      <= pop_data.destination_address;
            ident_reg    <= pop_data.identification;
            offset_reg   <= offset_next;
            more_reg     <= pop_data.flags_word[13];
            hdr_reg      <= pop_data.header_length;
            payload_reg  <= payload_next;
            recv_out_reg <= 32'(recv_next);
            drop_out_reg <= 32'(drop_next);
        end
    end

    assign result.valid               = valid_reg;
    assign result.verdict             = verdict_reg;
    assign result.protocol            = proto_reg;
    assign result.src_address         = src_reg;
    assign result.destination_address = dst_reg;
    assign result.identification      = ident_reg;
    assign result.fragment_offset     = offset_reg;
    assign result.more_frag           = more_reg;
    assign result.header_length       = hdr_reg;
    assign result.payload_length      = payload_reg;
    assign result.received_count      = recv_out_reg;
    assign result.dropped_count       = drop_out_reg;

endmodule

FILE: hw/rtl/ipv4_receive_header_check_unit.sv
// Top level: IPv4 receive header check unit with APB configuration port.
//
// Usage: packet bytes enter on rx, one per transfer, header first, with
// frame_last set on the final byte of the frame. Each frame yields exactly one
// transfer on result: drop, deliver whole or pass to reassembly, with the
// captured header fields and the wrapping received/dropped counters.
// Throughput: one byte per cycle while the queue has room; frames back to back.
// Path: the front end classifies the frame on the last byte and pushes its
// summary into a two-entry queue as that byte is taken; the back end then pops
// it, filters the destination and loads the output register, which drives
// result.
// Stall: while result is held off, the output register keeps its item, the
// back end stops and the queue fills; rx stays ready until the queue is full.
// Reset: rst_n clears the per-frame capture, the queue, the output valid, the
// counters and the configuration registers (interface disabled).
// Registers: 0x0 interface_enabled, 0x4 local_address, 0x8 dhcp_negotiating;
// write them only while no frame is in flight.
module ipv4_receive_header_check_unit
    import ihrc_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    ihrc_byte_if.sink      rx,
    ihrc_result_if.source  result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    cfg_t         cfg_reg;
    logic         cfg_write;
    logic         push_valid;
    logic         push_ready;
    pkt_summary_t push_data;
    logic         pop_valid;
    logic         pop_ready;
    pkt_summary_t pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ENABLE:     cfg_reg.interface_enabled <= pwdata[0];
                REG_LOCAL_ADDR: cfg_reg.local_address     <= pwdata;
                REG_DHCP:       cfg_reg.dhcp_negotiating  <= pwdata[0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLE:     prdata = {31'd0, cfg_reg.interface_enabled};
            REG_LOCAL_ADDR: prdata = cfg_reg.local_address;
            REG_DHCP:       prdata = {31'd0, cfg_reg.dhcp_negotiating};
            default:        prdata = '0;
        endcase
    end

    ihrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    ihrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ihrc_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

FILE: hw/rtl/ihrc_checker.sv
// Checker: port-level properties of the IPv4 receive header check unit.
module ihrc_checker
    import ihrc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  verdict,
    input logic [15:0] fragment_offset,
    input logic        more_frag,
    input logic [5:0]  header_length,
    input logic [15:0] payload_length
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(verdict)
            && $stable(payload_length))
        else $error("result changed while stalled");

    a_drop_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && verdict == VERDICT_DROP |-> payload_length == 16'd0)
        else $error("dropped packet reports payload");

    a_kept_header_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && verdict != VERDICT_DROP |-> header_length >= 6'd20)
        else $error("accepted packet with short header");

    a_deliver_whole: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && verdict == VERDICT_DELIVER |-> !more_frag
            && fragment_offset == 16'd0)
        else $error("delivered packet is a fragment");

endmodule

bind ipv4_receive_header_check_unit ihrc_checker u_ihrc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .verdict         (result.verdict),
    .fragment_offset (result.fragment_offset),
    .more_frag       (result.more_frag),
    .header_length   (result.header_length),
    .payload_length  (result.payload_length)
);

FILE: dv/ihrc_verdict_checker.sv
// Checker: predicts each packet verdict from the observed byte stream and compares the result.
module ihrc_verdict_checker
    import ihrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ihrc_byte_if        rx,
    ihrc_result_if      result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          pending,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  protocol;
        logic [31:0] src_address;
        logic [31:0] destination_address;
        logic [15:0] identification;
        logic [15:0] fragment_offset;
        logic        more_frag;
        logic [5:0]  header_length;
        logic [15:0] payload_length;
        logic [31:0] received_count;
        logic [31:0] dropped_count;
    } packet_verdict_t;

    packet_verdict_t verdict_q[$];
    cfg_t            cfg;
    logic [15:0]     byte_idx;
    logic [16:0]     csum;
    logic [7:0]      hi_hold;
    logic [7:0]      ver_ihl;
    logic [7:0]      proto;
    logic [15:0]     tot_len;
    logic [15:0]     ident;
    logic [15:0]     flags;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [31:0]     rx_total;
    logic [31:0]     drop_total;

    function automatic void clear_capture();
        byte_idx = '0;
        csum     = '0;
        hi_hold  = '0;
        ver_ihl  = '0;
        proto    = '0;
        tot_len  = '0;
        ident    = '0;
        flags    = '0;
        src      = '0;
        dst      = '0;
    endfunction

    function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected,
                     actual);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict
        logic [15:0]     hdr_len;
        logic [15:0]     frame_size;
        logic [31:0]     word_sum;
        logic            drop;
        logic            accept;
        packet_verdict_t want;
        if (!rst_n)
        begin
            cfg        = '0;
            rx_total   = '0;
            drop_total = '0;
            clear_capture();
            verdict_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ENABLE:     cfg.interface_enabled = pwdata[0];
                    REG_LOCAL_ADDR: cfg.local_address     = pwdata;
                    REG_DHCP:       cfg.dhcp_negotiating  = pwdata[0];
                    default:        ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result transfer with no packet outstanding", $time);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("verdict", 32'(want.verdict), 32'(result.verdict));
                    check_field("protocol", 32'(want.protocol), 32'(result.protocol));
                    check_field("src_address", want.src_address,
                                result.src_address);
                    check_field("destination_address", want.destination_address,
                                result.destination_address);
                    check_field("identification", 32'(want.identification),
                                32'(result.identification));
                    check_field("fragment_offset", 32'(want.fragment_offset),
                                32'(result.fragment_offset));
                    check_field("more_frag", 32'(want.more_frag),
                                32'(result.more_frag));
                    check_field("header_length", 32'(want.header_length),
                                32'(result.header_length));
                    check_field("payload_length", 32'(want.payload_length),
                                32'(result.payload_length));
                    check_field("received_count", want.received_count,
                                result.received_count);
                    check_field("dropped_count", want.dropped_count, result.dropped_count);
                end
            end

            if (rx.valid && rx.ready)
            begin
                case (byte_idx)
                    OFS_VERSION_IHL: ver_ihl       = rx.data_byte;
                    OFS_TLEN_HI:     tot_len[15:8] = rx.data_byte;
                    OFS_TLEN_LO:     tot_len[7:0]  = rx.data_byte;
                    OFS_IDENT_HI:    ident[15:8]   = rx.data_byte;
                    OFS_IDENT_LO:    ident[7:0]    = rx.data_byte;
                    OFS_FLAGS_HI:    flags[15:8]   = rx.data_byte;
                    OFS_FLAGS_LO:    flags[7:0]    = rx.data_byte;
                    OFS_PROTOCOL:    proto         = rx.data_byte;
                    default:
                    begin
                        if (byte_idx >= OFS_SOURCE && byte_idx < OFS_DEST)
                            src = {src[23:0], rx.data_byte};
                        else if (byte_idx >= OFS_DEST && byte_idx <= OFS_DEST_END)
                            dst = {dst[23:0], rx.data_byte};
                    end
                endcase

                hdr_len = {10'd0, ver_ihl[3:0], 2'b00};
                if (byte_idx < hdr_len)
                begin
                    if (!byte_idx[0])
                        hi_hold = rx.data_byte;
                    else
                    begin
                        word_sum = {15'd0, csum} + {16'd0, hi_hold, rx.data_byte};
                        csum = 17'(word_sum[15:0]) + 17'(word_sum[31:16]);
                    end
                end

                frame_size = (byte_idx == BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : byte_idx + 16'd1;
                byte_idx = frame_size;

                if (rx.frame_last)
                begin
                    drop = frame_size < MIN_HEADER_BYTES || ver_ihl[7:4] != IP_VERSION_4;
                    if (!drop)
                        drop = hdr_len < MIN_HEADER_BYTES || hdr_len > frame_size
                            || tot_len < hdr_len || tot_len > frame_size
                            || csum != {1'b0, CHECKSUM_GOOD};
                    if (!drop)
                    begin
                        accept = dst == cfg.local_address || dst == ADDR_BROADCAST
                            || dst[31:24] == LOOPBACK_NET
                            || (cfg.dhcp_negotiating && proto == PROTO_UDP);
                        drop = !cfg.interface_enabled || !accept;
                    end
                    if (drop)
                        drop_total = drop_total + 32'd1;
                    else
                        rx_total = rx_total + 32'd1;

                    want.more_frag           = flags[13];
                    want.fragment_offset     = {flags[12:0], 3'b000};
                    if (drop)
                        want.verdict = VERDICT_DROP;
                    else if (!want.more_frag && want.fragment_offset == '0)
                        want.verdict = VERDICT_DELIVER;
                    else
                        want.verdict = VERDICT_FRAGMENT;
                    want.protocol            = proto;
                    want.src_address         = src;
                    want.destination_address = dst;
                    want.identification      = ident;
                    want.header_length       = hdr_len[5:0];
                    want.payload_length      = drop ? 16'd0 : tot_len - hdr_len;
                    want.received_count      = rx_total;
                    want.dropped_count       = drop_total;
                    verdict_q.push_back(want);
                    clear_capture();
                end
            end
            pending = verdict_q.size();
        end
    end

endmodule

FILE: dv/ipv4_receive_header_check_unit_tb.sv
// Testbench top: drives IPv4 frames and register writes into the header check unit.
module ipv4_receive_header_check_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ihrc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          pending;
    int          fail_count;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    logic [31:0] local_addr;
    logic [7:0]  frame[$];
    int          phase_bytes;
    int          phase_frames;

    ihrc_byte_if   rx ();
    ihrc_result_if result ();

    ipv4_receive_header_check_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ihrc_verdict_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

    // hold result off for a long stretch on request, else stall at random
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            result.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic cfg_write(input logic [1:0] reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic put_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid      <= 1'b1;
        rx.data_byte  <= value;
        rx.frame_last <= last;
        do @(posedge clk); while (!rx.ready);
    endtask

    task automatic send_frame();
        foreach (frame[i])
            put_byte(frame[i], i == frame.size() - 1);
        phase_bytes += frame.size();
        phase_frames++;
    endtask

    // hold the byte channel idle until every verdict is out
    task automatic drain();
        rx.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic void build_packet(input logic [3:0] version, input logic [3:0] ihl,
                                         input int payload, input int total_adj,
                                         input logic [7:0] proto, input logic [31:0] dst,
                                         input logic [15:0] flags, input int pad);
        logic [15:0] total;
        logic [31:0] sum;
        int          hdr;
        hdr   = ihl * 4;
        total = 16'(hdr + payload + total_adj);
        frame.delete();
        frame.push_back({version, ihl});
        frame.push_back(8'($urandom));
        frame.push_back(total[15:8]);
        frame.push_back(total[7:0]);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(flags[15:8]);
        frame.push_back(flags[7:0]);
        frame.push_back(8'($urandom));
        frame.push_back(proto);
        frame.push_back(8'd0);
        frame.push_back(8'd0);
        repeat (4) frame.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--)
            frame.push_back(dst[8*i +: 8]);
        while (frame.size() < hdr)
            frame.push_back(8'($urandom));
        sum = '0;
        for (int i = 0; i < hdr; i += 2)
        begin
            sum = sum + {16'd0, frame[i], frame[i+1]};
            sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
        end
        frame[10] = ~sum[15:8];
        frame[11] = ~sum[7:0];
        repeat (payload + pad) frame.push_back(8'($urandom));
    endfunction

    task automatic send_random_frame();
        logic [31:0] dst;
        logic [3:0]  version;
        logic [3:0]  ihl;
        int          pick;
        int          cut;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            frame.delete();
            repeat ($urandom_range(30, 1)) frame.push_back(8'($urandom));
        end
        else
        begin
            case ($urandom_range(3))
                0:       dst = local_addr;
                1:       dst = ADDR_BROADCAST;
                2:       dst = {LOOPBACK_NET, 24'($urandom)};
                default: dst = $urandom;
            endcase
            version = ($urandom_range(9) == 0) ? 4'($urandom) : IP_VERSION_4;
            ihl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5 + 4'($urandom_range(1));
            build_packet(version, ihl, $urandom_range(24),
                         ($urandom_range(6) == 0) ? int'($urandom_range(40)) - 30 : 0,
                         ($urandom_range(2) == 0) ? PROTO_UDP : 8'($urandom), dst,
                         ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom),
                         ($urandom_range(2) == 0) ? int'($urandom_range(4, 1)) : 0);
            if (pick < 20)
                frame[$urandom_range(19)] ^= 8'(1 << $urandom_range(7));
            else if (pick < 30)
            begin
                cut = $urandom_range(frame.size() - 1, 1);
                while (frame.size() > cut)
                    void'(frame.pop_back());
            end
        end
        send_frame();
    endtask

    task automatic run_phase(input int min_bytes, input int min_frames);
        phase_bytes  = 0;
        phase_frames = 0;
        while (phase_bytes < min_bytes || phase_frames < min_frames)
            send_random_frame();
    endtask

    initial
    begin
        send_idle_pct = 16;
        recv_idle_pct = 48;
        hold_request  = 1'b0;
        local_addr    = '0;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rx.valid      <= 1'b0;
        rx.data_byte  <= '0;
        rx.frame_last <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // interface still disabled: a good packet is dropped
        build_packet(IP_VERSION_4, 4'd5, 8, 0, 8'd6, 32'd0, 16'd0, 0);
        send_frame();
        drain();

        local_addr = $urandom;
        cfg_write(REG_ENABLE, 32'd1);
        cfg_write(REG_LOCAL_ADDR, local_addr);
        cfg_write(REG_DHCP, 32'd0);

        build_packet(IP_VERSION_4, 4'd5, 4, 0, 8'd6, local_addr, 16'd0, 0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd5, 3, 0, 8'd1, ADDR_BROADCAST, 16'h2000, 2);
        send_frame();
        build_packet(IP_VERSION_4, 4'd15, 0, 0, 8'hff, {LOOPBACK_NET, 24'd1}, 16'hffff, 0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd5, 6, 0, PROTO_UDP, 32'h0a00_0001, 16'd0, 0);
        send_frame();
        build_packet(4'd6, 4'd5, 2, 0, 8'd6, local_addr, 16'd0, 0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd4, 2, 0, 8'd6, local_addr, 16'd0, 0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd5, 4, -5, 8'd6, local_addr, 16'd0, 0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd5, 4, 3, 8'd6, local_addr, 16'd0, 2);
        send_frame();
        build_packet(IP_VERSION_4, 4'd5, 4, 0, 8'd6, local_addr, 16'd0, 0);
        frame[10] ^= 8'h01;
        send_frame();
        build_packet(IP_VERSION_4, 4'd5, 0, 0, 8'd6, local_addr, 16'd0, 0);
        void'(frame.pop_back());
        send_frame();
        build_packet(IP_VERSION_4, 4'd15, 0, 0, 8'd6, local_addr, 16'd0, 0);
        while (frame.size() > 40)
            void'(frame.pop_back());
        send_frame();
        frame = '{8'hff};
        send_frame();
        frame = '{8'h00};
        send_frame();
        frame = '{8'h45, 8'h00, 8'h00};
        send_frame();
        drain();

        cfg_write(REG_DHCP, 32'd1);
        build_packet(IP_VERSION_4, 4'd5, 5, 0, PROTO_UDP, 32'h0102_0304, 16'd0, 0);
        send_frame();
        build_packet(IP_VERSION_4, 4'd5, 5, 0, 8'd6, 32'h0102_0304, 16'd0, 0);
        send_frame();
        drain();
        cfg_write(REG_DHCP, 32'd0);

        run_phase(60, 2);
        drain();

        send_idle_pct = 48;
        recv_idle_pct = 16;
        local_addr    = 32'hffff_ffff;
        cfg_write(REG_LOCAL_ADDR, local_addr);
        cfg_write(REG_DHCP, 32'd1);
        run_phase(60, 2);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        local_addr    = 32'd0;
        cfg_write(REG_LOCAL_ADDR, local_addr);
        cfg_write(REG_DHCP, 32'd0);
        run_phase(30, 1);
        // stall the result side while short frames keep coming
        hold_request = 1'b1;
        repeat (12)
        begin
            frame.delete();
            repeat ($urandom_range(3, 1)) frame.push_back(8'($urandom));
            send_frame();
        end
        run_phase(30, 1);
        drain();

        cfg_write(REG_ENABLE, 32'd0);
        cfg_write(REG_DHCP, 32'd1);
        run_phase(30, 1);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ihrc_pkg.sv
hw/rtl/ihrc_byte_if.sv
hw/rtl/ihrc_result_if.sv
hw/rtl/ihrc_front.sv
hw/rtl/ihrc_queue.sv
hw/rtl/ihrc_back.sv
hw/rtl/ipv4_receive_header_check_unit.sv
hw/rtl/ihrc_checker.sv
dv/ihrc_verdict_checker.sv
dv/ipv4_receive_header_check_unit_tb.sv
